@@ design/tphb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphb_pkg
// Shared types, constants and the temperature-to-period table of the
// temperature-paced heartbeat blinker.
// ----------------------------------------------------------------------------
package tphb_pkg;

	// Timing and filter constants
	localparam int TICKS_PER_SECOND = 1000;
	localparam int CONFIRM_DEPTH    = 4;
	localparam int TEMP_HOT         = 80;
	localparam int TEMP_MIN         = -40;
	localparam int TEMP_SPAN        = TEMP_HOT - TEMP_MIN;
	localparam int PERIOD_W         = 11;
	localparam int PERIOD_MAX       = (1 << PERIOD_W) - 1;
	localparam int TEMP_W           = 8;
	localparam int TEMP_CODES       = 1 << TEMP_W;
	localparam int TIME_W           = 32;
	localparam int CNT_W            = (CONFIRM_DEPTH > 2) ? $clog2(CONFIRM_DEPTH) : 1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CHECK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_PRESENT       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_PRESENT    = 2'd2;

	// Stream widths
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_OFF,
		MODE_ON,
		MODE_DISABLED
	} mode_t;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [PERIOD_W-1:0]      period_t;

	// One poll, last field in the lowest bits
	typedef struct packed {
		logic              led_write_ok;
		logic              temp_second_ok;
		temp_t             temp_second;
		logic              temp_first_ok;
		temp_t             temp_first;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	// One result, last field in the lowest bits
	typedef struct packed {
		temp_t   filtered_temp_out;
		period_t blink_period;
		logic    led_disabled;
		logic    led_written;
		logic    led_on;
	} result_t;

	// Static configuration seen by the period filter
	typedef struct packed {
		logic temp_check_enable;
		logic sensor_present;
	} ctrl_t;

	// Clamp a period into the field range
	function automatic period_t sat_period(input longint p);
		longint c;
		c = p;
		if (c < 0) begin
			c = 0;
		end
		if (c > PERIOD_MAX) begin
			c = PERIOD_MAX;
		end
		return PERIOD_W'(c);
	endfunction

	localparam period_t PERIOD_FIXED = sat_period(longint'(TICKS_PER_SECOND));
	localparam period_t PERIOD_FAULT = sat_period(longint'(TICKS_PER_SECOND / 2));

	typedef period_t period_table_t [TEMP_CODES];

	// Period for every temperature code, built at elaboration
	function automatic period_table_t build_period_table();
		period_table_t tbl;
		longint t;
		longint hz;
		hz = longint'(TICKS_PER_SECOND);
		for (int i = 0; i < TEMP_CODES; i++) begin
			t = (i >= TEMP_CODES / 2) ? longint'(i - TEMP_CODES) : longint'(i);
			tbl[i] = sat_period(hz + hz / 10 - (t - TEMP_MIN) * hz / TEMP_SPAN);
		end
		return tbl;
	endfunction

	localparam period_table_t PERIOD_TABLE = build_period_table();

endpackage

@@ design/tphb_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphb_filter
// Temperature confirmation filter and blink period lookup. State moves only
// on a period evaluation.
// ----------------------------------------------------------------------------
module tphb_filter (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tphb_pkg::ctrl_t         ctrl,
	input  logic                    eval,
	input  tphb_pkg::temp_t         temp_first,
	input  logic                    temp_first_ok,
	input  tphb_pkg::temp_t         temp_second,
	input  logic                    temp_second_ok,
	output tphb_pkg::period_t       period,
	output tphb_pkg::temp_t         temp_next
);

	localparam logic [tphb_pkg::CNT_W-1:0] CNT_LAST =
		tphb_pkg::CNT_W'(tphb_pkg::CONFIRM_DEPTH - 1);

	tphb_pkg::temp_t             acc_temp_q;
	logic                        acc_valid_q;
	logic [tphb_pkg::CNT_W-1:0]  cnt_q;
	tphb_pkg::temp_t             samples_q [tphb_pkg::CONFIRM_DEPTH];

	tphb_pkg::temp_t             acc_temp_d;
	logic                        acc_valid_d;
	logic [tphb_pkg::CNT_W-1:0]  cnt_d;
	logic                        sample_we;
	logic                        fault;
	logic                        all_same;

	// Compare stored samples of this round against the new reading
	always_comb begin
		all_same = (temp_second == temp_first);
		for (int i = 0; i < tphb_pkg::CONFIRM_DEPTH - 1; i++) begin
			if (samples_q[i] != temp_first) begin
				all_same = 1'b0;
			end
		end
	end

	// Next filter state and period
	always_comb begin
		acc_temp_d  = acc_temp_q;
		acc_valid_d = acc_valid_q;
		cnt_d       = cnt_q;
		sample_we   = 1'b0;
		fault       = 1'b0;
		period      = tphb_pkg::PERIOD_FIXED;
		if (ctrl.temp_check_enable) begin
			if (!ctrl.sensor_present || !temp_first_ok) begin
				fault = 1'b1;
			end else if (!acc_valid_q) begin
				acc_temp_d  = temp_first;
				acc_valid_d = 1'b1;
			end else if (temp_first != acc_temp_q) begin
				if (!temp_second_ok) begin
					fault = 1'b1;
				end else begin
					sample_we = 1'b1;
					if (cnt_q == CNT_LAST) begin
						cnt_d = '0;
						if (all_same) begin
							acc_temp_d = temp_first;
						end
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end else begin
				cnt_d = '0;
			end
			period = fault ? tphb_pkg::PERIOD_FAULT
				: tphb_pkg::PERIOD_TABLE[$unsigned(acc_temp_d)];
		end
		temp_next = eval ? acc_temp_d : acc_temp_q;
	end

	// Hold filter control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_temp_q  <= '0;
			acc_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (eval) begin
			acc_temp_q  <= acc_temp_d;
			acc_valid_q <= acc_valid_d;
			cnt_q       <= cnt_d;
		end
	end

	// Store confirming readings
	always_ff @(posedge clk) begin
		if (eval && sample_we) begin
			samples_q[cnt_q] <= temp_second;
		end
	end

endmodule

@@ design/tphb_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphb_core
// LED mode sequencer: lights the LED on the first poll, toggles it once the
// blink period has elapsed and drops to disabled on a refused write.
// ----------------------------------------------------------------------------
module tphb_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tphb_pkg::ctrl_t      ctrl,
	input  logic                 led_cfg_we,
	input  logic                 led_cfg_val,
	input  logic                 step,
	input  tphb_pkg::item_t      item,
	output tphb_pkg::result_t    result
);

	tphb_pkg::mode_t                mode_q;
	tphb_pkg::mode_t                mode_d;
	logic [tphb_pkg::TIME_W-1:0]    last_q;
	tphb_pkg::period_t              period_q;
	logic [tphb_pkg::TIME_W-1:0]    elapsed;
	logic                           due;
	logic                           eval;
	logic                           written;
	tphb_pkg::period_t              new_period;
	tphb_pkg::temp_t                temp_next;

	tphb_filter u_filter (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.eval           (eval),
		.temp_first     (item.temp_first),
		.temp_first_ok  (item.temp_first_ok),
		.temp_second    (item.temp_second),
		.temp_second_ok (item.temp_second_ok),
		.period         (new_period),
		.temp_next      (temp_next)
	);

	// Elapsed time with wrap, against the current period
	assign elapsed = item.now_ms - last_q;
	assign due     = elapsed > tphb_pkg::TIME_W'(period_q);

	// Next mode and result
	always_comb begin
		mode_d  = mode_q;
		eval    = 1'b0;
		written = 1'b0;
		case (mode_q)
			tphb_pkg::MODE_INIT: begin
				eval = step;
			end
			tphb_pkg::MODE_ON, tphb_pkg::MODE_OFF: begin
				eval = step && due;
			end
			default: begin
				eval = 1'b0;
			end
		endcase
		if (eval) begin
			if (item.led_write_ok) begin
				written = 1'b1;
				mode_d  = (mode_q == tphb_pkg::MODE_ON) ? tphb_pkg::MODE_OFF
					: tphb_pkg::MODE_ON;
			end else begin
				mode_d = tphb_pkg::MODE_DISABLED;
			end
		end
		result.led_on            = (mode_d == tphb_pkg::MODE_ON);
		result.led_written       = written;
		result.led_disabled      = (mode_d == tphb_pkg::MODE_DISABLED);
		result.blink_period      = eval ? new_period : period_q;
		result.filtered_temp_out = temp_next;
	end

	// Hold mode, toggle time and period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tphb_pkg::MODE_DISABLED;
			last_q   <= '0;
			period_q <= '0;
		end else if (led_cfg_we) begin
			mode_q <= led_cfg_val ? tphb_pkg::MODE_INIT : tphb_pkg::MODE_DISABLED;
		end else if (eval) begin
			mode_q   <= mode_d;
			last_q   <= item.now_ms;
			period_q <= new_period;
		end
	end

endmodule

@@ design/temperature_paced_heartbeat_blinker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_paced_heartbeat_blinker_top
// Heartbeat LED pacer: one result item per poll item, with an input register,
// a state update and a result register.
// ----------------------------------------------------------------------------
// The block takes one poll item per clock and returns exactly one result item
// for it: the item is captured in the input register, the LED mode, toggle
// time and temperature filter are evaluated as it moves on to the result
// register, and the result sits in the output register until taken. The
// state update from one poll to the next sets the rate of one item per
// clock; it holds as long as the result side keeps taking items.
// There is no clearing pass after reset.
module temperature_paced_heartbeat_blinker_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// now_ms[31:0], temp_first[39:32], temp_first_ok[40], temp_second[48:41],
	// temp_second_ok[49], led_write_ok[50], zero[55:51]
	input  logic [tphb_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// led_on[0], led_written[1], led_disabled[2], blink_period[13:3],
	// filtered_temp_out[21:14], zero[23:22]
	output logic [tphb_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [tphb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                              cfg_data
);

	localparam int ITEM_W = $bits(tphb_pkg::item_t);
	localparam int RES_W  = $bits(tphb_pkg::result_t);

	tphb_pkg::ctrl_t     ctrl_q;
	tphb_pkg::item_t     item_s1;
	logic                valid_s1;
	tphb_pkg::result_t   result;
	tphb_pkg::result_t   result_s2;
	logic                valid_s2;
	logic                step;
	logic                led_cfg_we;

	// Advance when the result register is free or being emptied
	assign step       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready   = !valid_s1 || step;
	assign led_cfg_we = cfg_we && (cfg_index == tphb_pkg::CFG_LED_PRESENT);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.temp_check_enable <= 1'b1;
			ctrl_q.sensor_present    <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == tphb_pkg::CFG_TEMP_CHECK_ENABLE) begin
				ctrl_q.temp_check_enable <= cfg_data;
			end
			if (cfg_index == tphb_pkg::CFG_SENSOR_PRESENT) begin
				ctrl_q.sensor_present <= cfg_data;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= tphb_pkg::item_t'(s_tdata[ITEM_W-1:0]);
		end
	end

	tphb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl_q),
		.led_cfg_we  (led_cfg_we),
		.led_cfg_val (cfg_data),
		.step        (step),
		.item        (item_s1),
		.result      (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(tphb_pkg::M_TDATA_W - RES_W)'(0), result_s2};

endmodule
